/* rtl/iae_pkg.sv */
`default_nettype none

package iae_pkg;

  // Mnemonic codes
  localparam logic [4:0] ACT_MOV  = 5'd0;
  localparam logic [4:0] ACT_ADD  = 5'd1;
  localparam logic [4:0] ACT_CMP  = 5'd6;
  localparam logic [4:0] ACT_INC  = 5'd7;
  localparam logic [4:0] ACT_DEC  = 5'd8;
  localparam logic [4:0] ACT_NOT  = 5'd9;
  localparam logic [4:0] ACT_PUSH = 5'd13;
  localparam logic [4:0] ACT_POP  = 5'd14;
  localparam logic [4:0] ACT_JMP  = 5'd15;
  localparam logic [4:0] ACT_JE   = 5'd16;
  localparam logic [4:0] ACT_JGE  = 5'd21;
  localparam logic [4:0] ACT_CALL = 5'd22;
  localparam logic [4:0] ACT_LEA  = 5'd23;
  localparam logic [4:0] ACT_NOP  = 5'd24;
  localparam logic [4:0] ACT_RET  = 5'd25;
  localparam logic [4:0] ACT_INT  = 5'd26;

  // Operand kinds
  localparam logic [3:0] K_NONE   = 4'd0;
  localparam logic [3:0] K_REG    = 4'd1;
  localparam logic [3:0] K_IMM    = 4'd2;
  localparam logic [3:0] K_LABEL  = 4'd3;
  localparam logic [3:0] K_DIRECT = 4'd4;
  localparam logic [3:0] K_BASE   = 4'd5;
  localparam logic [3:0] K_BDISP  = 4'd6;
  localparam logic [3:0] K_BIDX   = 4'd7;
  localparam logic [3:0] K_SIB    = 4'd8;

  // Error codes
  localparam logic [2:0] E_OK    = 3'd0;
  localparam logic [2:0] E_MNEM  = 3'd1;
  localparam logic [2:0] E_COMBO = 3'd2;
  localparam logic [2:0] E_REG   = 3'd3;
  localparam logic [2:0] E_MEM   = 3'd4;
  localparam logic [2:0] E_MISS  = 3'd5;

  localparam int MAX_BYTES = 11;

  // Opcode bytes
  localparam logic [7:0] OP_MOV_MR   = 8'h89;
  localparam logic [7:0] OP_MOV_RM   = 8'h8B;
  localparam logic [7:0] OP_MOV_MI   = 8'hC7;
  localparam logic [7:0] OP_ALU_I    = 8'h81;
  localparam logic [7:0] OP_GRP3     = 8'hF7;
  localparam logic [7:0] OP_MOV_RI   = 8'hB8;
  localparam logic [7:0] OP_JMP      = 8'hE9;
  localparam logic [7:0] OP_ESC      = 8'h0F;
  localparam logic [7:0] OP_CALL     = 8'hE8;
  localparam logic [7:0] OP_INT      = 8'hCD;
  localparam logic [7:0] OP_GRP5     = 8'hFF;
  localparam logic [7:0] OP_LEA      = 8'h8D;
  localparam logic [7:0] OP_INC_R    = 8'h40;
  localparam logic [7:0] OP_DEC_R    = 8'h48;
  localparam logic [7:0] OP_PUSH_R   = 8'h50;
  localparam logic [7:0] OP_POP_R    = 8'h58;
  localparam logic [7:0] OP_NOP      = 8'h90;
  localparam logic [7:0] OP_RET      = 8'hC3;
  localparam logic [7:0] SIB_ESP     = 8'h24;

  localparam logic [5:0][7:0] ALU_MR    = {8'h39, 8'h31, 8'h09, 8'h21, 8'h29, 8'h01};
  localparam logic [5:0][2:0] ALU_SLASH = {3'd7, 3'd6, 3'd1, 3'd4, 3'd5, 3'd0};
  localparam logic [3:0][2:0] UN_SLASH  = {3'd6, 3'd4, 3'd3, 3'd2};
  localparam logic [5:0][7:0] JCC_OP    = {8'h8D, 8'h8F, 8'h8E, 8'h8C, 8'h85, 8'h84};

  // Encoded instruction: bytes in emission order, byte count, error code
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] b;
    logic [3:0]                n;
    logic [2:0]                err;
  } enc_t;

endpackage

`default_nettype wire

/* rtl/iae_encode.sv */
`default_nettype none

module iae_encode import iae_pkg::*; (
  input  wire logic [4:0]  action,
  input  wire logic [3:0]  dst_kind,
  input  wire logic [3:0]  src_kind,
  input  wire logic [3:0]  dst_reg,
  input  wire logic [3:0]  src_reg,
  input  wire logic [2:0]  mem_index,
  input  wire logic [1:0]  mem_scale,
  input  wire logic [31:0] mem_disp,
  input  wire logic [31:0] imm_value,
  input  wire logic [31:0] instr_address,
  input  wire logic        target_symbolic,
  output enc_t             enc
);

  function automatic enc_t put(input enc_t e, input logic [7:0] v);
    enc_t r;
    r = e;
    if (r.n < 4'(MAX_BYTES)) begin
      r.b[r.n] = v;
      r.n = r.n + 4'd1;
    end
    return r;
  endfunction

  function automatic enc_t put32(input enc_t e, input logic [31:0] v);
    enc_t r;
    r = put(e, v[7:0]);
    r = put(r, v[15:8]);
    r = put(r, v[23:16]);
    r = put(r, v[31:24]);
    return r;
  endfunction

  function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] rg,
                                       input logic [2:0] rm);
    return {md, rg, rm};
  endfunction

  function automatic logic is_mem(input logic [3:0] k);
    return (k >= K_DIRECT) && (k <= K_SIB);
  endfunction

  function automatic logic is_immk(input logic [3:0] k);
    return (k == K_IMM) || (k == K_LABEL);
  endfunction

  // ModRM, optional SIB and displacement of one memory operand
  function automatic enc_t mem_enc(input logic [3:0] kind, input logic [3:0] base,
                                   input logic [2:0] rf, input logic [31:0] d,
                                   input logic [2:0] idx, input logic [1:0] sc);
    enc_t e;
    logic [1:0] md;
    logic       f8;
    e  = '0;
    md = 2'd0;
    f8 = (d[31:7] == '0) || (d[31:7] == '1);
    if (!is_mem(kind)) begin
      e.err = E_MEM;
    end else if (kind == K_DIRECT) begin
      e = put(e, modrm(2'd0, rf, 3'd5));
      e = put32(e, d);
    end else if (base[3]) begin
      e.err = E_REG;
    end else begin
      case (kind)
        K_BASE: begin
          if (base[2:0] == 3'd4) begin
            e = put(e, modrm(2'd0, rf, 3'd4));
            e = put(e, SIB_ESP);
          end else if (base[2:0] == 3'd5) begin
            // EBP base has no mod 00 form: zero disp8
            e = put(e, modrm(2'd1, rf, 3'd5));
            e = put(e, 8'h00);
          end else begin
            e = put(e, modrm(2'd0, rf, base[2:0]));
          end
        end
        K_BDISP: begin
          md = f8 ? 2'd1 : 2'd2;
          e = put(e, modrm(md, rf, base[2:0]));
          if (base[2:0] == 3'd4) e = put(e, SIB_ESP);
        end
        K_BIDX: begin
          md = (base[2:0] == 3'd5) ? 2'd1 : 2'd0;
          e = put(e, modrm(md, rf, 3'd4));
          e = put(e, modrm(2'd0, idx, base[2:0]));
        end
        default: begin
          if (d == 32'd0 && base[2:0] != 3'd5) md = 2'd0;
          else md = f8 ? 2'd1 : 2'd2;
          e = put(e, modrm(md, rf, 3'd4));
          e = put(e, modrm(sc, idx, base[2:0]));
        end
      endcase
      if (kind == K_BIDX) begin
        if (md == 2'd1) e = put(e, 8'h00);
      end else if (kind != K_BASE) begin
        if (md == 2'd1) e = put(e, d[7:0]);
        else if (md == 2'd2) e = put32(e, d);
      end
    end
    return e;
  endfunction

  // Append a memory-operand fragment (at most six bytes) and its error
  function automatic enc_t app(input enc_t e, input enc_t f);
    enc_t r;
    r = e;
    for (int i = 0; i < 6; i++) begin
      if (4'(i) < f.n) r = put(r, f.b[i]);
    end
    if (f.err != E_OK) r.err = f.err;
    return r;
  endfunction

  enc_t        e;
  logic [2:0]  a;
  logic [2:0]  sl;
  logic [31:0] rel_len;
  logic [31:0] rel;

  always_comb begin
    e       = '0;
    a       = 3'(action - ACT_ADD);
    sl      = UN_SLASH[2'(action - ACT_NOT)];
    rel_len = (action >= ACT_JE && action <= ACT_JGE) ? 32'd6 : 32'd5;
    rel     = (target_symbolic || dst_kind == K_LABEL) ?
              (imm_value - (instr_address + rel_len)) : imm_value;

    if (action == ACT_MOV) begin
      if (dst_kind == K_REG && is_immk(src_kind)) begin
        if (dst_reg[3]) e.err = E_REG;
        else begin
          e = put(e, OP_MOV_RI + {5'd0, dst_reg[2:0]});
          e = put32(e, imm_value);
        end
      end else if (src_kind == K_REG && (dst_kind == K_REG || is_mem(dst_kind))) begin
        if (src_reg[3] || (dst_kind == K_REG && dst_reg[3])) e.err = E_REG;
        else begin
          e = put(e, OP_MOV_MR);
          if (dst_kind == K_REG) e = put(e, modrm(2'd3, src_reg[2:0], dst_reg[2:0]));
          else e = app(e, mem_enc(dst_kind, dst_reg, src_reg[2:0], mem_disp,
                                  mem_index, mem_scale));
        end
      end else if (dst_kind == K_REG && is_mem(src_kind)) begin
        if (dst_reg[3]) e.err = E_REG;
        else begin
          e = put(e, OP_MOV_RM);
          e = app(e, mem_enc(src_kind, src_reg, dst_reg[2:0], mem_disp,
                             mem_index, mem_scale));
        end
      end else if (is_immk(src_kind) && is_mem(dst_kind)) begin
        e = put(e, OP_MOV_MI);
        e = app(e, mem_enc(dst_kind, dst_reg, 3'd0, mem_disp, mem_index, mem_scale));
        e = put32(e, imm_value);
      end else begin
        e.err = E_COMBO;
      end
    end else if (action <= ACT_CMP) begin
      if (is_immk(src_kind)) begin
        e = put(e, OP_ALU_I);
        if (dst_kind == K_REG) begin
          if (dst_reg[3]) e.err = E_REG;
          else e = put(e, modrm(2'd3, ALU_SLASH[a], dst_reg[2:0]));
        end else begin
          e = app(e, mem_enc(dst_kind, dst_reg, ALU_SLASH[a], mem_disp,
                             mem_index, mem_scale));
        end
        e = put32(e, imm_value);
      end else if (src_kind == K_REG && is_mem(dst_kind)) begin
        if (src_reg[3]) e.err = E_REG;
        else begin
          e = put(e, ALU_MR[a]);
          e = app(e, mem_enc(dst_kind, dst_reg, src_reg[2:0], mem_disp,
                             mem_index, mem_scale));
        end
      end else if (dst_kind == K_REG && (src_kind == K_REG || is_mem(src_kind))) begin
        if (dst_reg[3]) e.err = E_REG;
        else begin
          e = put(e, ALU_MR[a] + 8'd2);
          if (src_kind == K_REG) begin
            if (src_reg[3]) e.err = E_REG;
            else e = put(e, modrm(2'd3, dst_reg[2:0], src_reg[2:0]));
          end else begin
            e = app(e, mem_enc(src_kind, src_reg, dst_reg[2:0], mem_disp,
                               mem_index, mem_scale));
          end
        end
      end else begin
        e.err = E_COMBO;
      end
    end else if (action <= ACT_POP) begin
      if (dst_kind == K_NONE) e.err = E_MISS;
      else if (action >= ACT_PUSH) begin
        if (dst_kind != K_REG) e.err = E_COMBO;
        else if (dst_reg[3]) e.err = E_REG;
        else e = put(e, ((action == ACT_PUSH) ? OP_PUSH_R : OP_POP_R) +
                        {5'd0, dst_reg[2:0]});
      end else if (action <= ACT_DEC) begin
        if (dst_kind == K_REG) begin
          if (dst_reg[3]) e.err = E_REG;
          else e = put(e, ((action == ACT_INC) ? OP_INC_R : OP_DEC_R) +
                          {5'd0, dst_reg[2:0]});
        end else begin
          e = put(e, OP_GRP5);
          e = app(e, mem_enc(dst_kind, dst_reg, (action == ACT_DEC) ? 3'd1 : 3'd0,
                             mem_disp, mem_index, mem_scale));
        end
      end else begin
        e = put(e, OP_GRP3);
        if (dst_kind == K_REG) begin
          if (dst_reg[3]) e.err = E_REG;
          else e = put(e, modrm(2'd3, sl, dst_reg[2:0]));
        end else begin
          e = app(e, mem_enc(dst_kind, dst_reg, sl, mem_disp, mem_index, mem_scale));
        end
      end
    end else if (action <= ACT_CALL) begin
      if (dst_kind == K_NONE) e.err = E_MISS;
      else begin
        if (action == ACT_JMP) e = put(e, OP_JMP);
        else if (action == ACT_CALL) e = put(e, OP_CALL);
        else begin
          e = put(e, OP_ESC);
          e = put(e, JCC_OP[3'(action - ACT_JE)]);
        end
        e = put32(e, rel);
      end
    end else if (action == ACT_LEA) begin
      if (dst_kind != K_REG || !is_mem(src_kind)) e.err = E_COMBO;
      else if (dst_reg[3]) e.err = E_REG;
      else begin
        e = put(e, OP_LEA);
        e = app(e, mem_enc(src_kind, src_reg, dst_reg[2:0], mem_disp,
                           mem_index, mem_scale));
      end
    end else if (action == ACT_NOP) begin
      e = put(e, OP_NOP);
    end else if (action == ACT_RET) begin
      e = put(e, OP_RET);
    end else if (action == ACT_INT) begin
      if (dst_kind == K_NONE) e.err = E_MISS;
      else if (!is_immk(dst_kind)) e.err = E_COMBO;
      else begin
        e = put(e, OP_INT);
        e = put(e, imm_value[7:0]);
      end
    end else begin
      e.err = E_MNEM;
    end

    // Any failure collapses to a single zero byte carrying the code
    if (e.err != E_OK || e.n == 4'd0) begin
      e.b   = '0;
      e.n   = 4'd1;
      e.err = (e.err == E_OK) ? E_COMBO : e.err;
    end
    enc = e;
  end

endmodule

`default_nettype wire

/* rtl/ia32_instruction_encoder.sv */
`default_nettype none

// Channel  Dir  Handshake          Payload
// in_      in   in_tvalid/tready   in_tdata: decoded instruction, in_tuser: symbolic target
// out_     out  out_tvalid/tready  out_tdata: code byte, out_tlast: last byte,
//                                  out_tuser: error code
//
// A request is taken into an input register; the encoder works on it in one
// combinational pass and the whole encoding (1 to 11 bytes) is loaded into the
// byte buffer, which then hands out one byte per cycle while out_tready is high;
// the next request is taken while the buffer is still draining. Reset is
// synchronous, active low, and clears the valid flags only. A stall on
// out_tready holds the buffer and, once the input register is full, drops
// in_tready.

module ia32_instruction_encoder import iae_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [4:0] action, [8:5] dst_kind, [12:9] src_kind, [16:13] dst_reg,
  // [20:17] src_reg, [23:21] mem_index, [25:24] mem_scale, [57:26] mem_disp,
  // [89:58] imm_value, [121:90] instr_address, [127:122] zero
  input  wire logic [127:0] in_tdata,
  // [0] target_symbolic
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [7:0] out_byte
  output logic [7:0]        out_tdata,
  output logic              out_tlast,
  // [2:0] error_code
  output logic [2:0]        out_tuser
);

  // Input register
  logic         a_vld_r;
  logic [121:0] a_data_r;
  logic         a_sym_r;

  // Byte buffer
  logic                      busy_r;
  logic [MAX_BYTES-1:0][7:0] buf_r;
  logic [3:0]                last_r;
  logic [3:0]                idx_r;
  logic [2:0]                err_r;

  enc_t enc;
  logic out_fire;
  logic done;
  logic load_b;

  assign out_fire  = out_tvalid && out_tready;
  assign done      = out_fire && out_tlast;
  assign load_b    = a_vld_r && (!busy_r || done);
  assign in_tready = !a_vld_r || load_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_tready) begin
      a_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_data_r <= in_tdata[121:0];
      a_sym_r  <= in_tuser;
    end
  end

  iae_encode u_enc (
    .action          (a_data_r[4:0]),
    .dst_kind        (a_data_r[8:5]),
    .src_kind        (a_data_r[12:9]),
    .dst_reg         (a_data_r[16:13]),
    .src_reg         (a_data_r[20:17]),
    .mem_index       (a_data_r[23:21]),
    .mem_scale       (a_data_r[25:24]),
    .mem_disp        (a_data_r[57:26]),
    .imm_value       (a_data_r[89:58]),
    .instr_address   (a_data_r[121:90]),
    .target_symbolic (a_sym_r),
    .enc             (enc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load_b) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      buf_r  <= enc.b;
      last_r <= enc.n - 4'd1;
      err_r  <= enc.err;
      idx_r  <= 4'd0;
    end else if (out_fire) begin
      idx_r  <= idx_r + 4'd1;
    end
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = buf_r[idx_r];
  assign out_tlast  = (idx_r == last_r);
  assign out_tuser  = err_r;

endmodule

`default_nettype wire
